// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define TCW_ASSERT(lbl, clk, rst_n, prop)
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// File: rtl/core/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = ATTR_W + CHAR_W;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_W = 11;
  localparam int PTR_W  = $clog2(CELL_COUNT + 1);

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] RESET_COLOR  = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_COLOR, SPACE_CODE};

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [ADDR_W-1:0] cursor_offset;
  } out_item_t;

endpackage

// File: rtl/core/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/text_console_writer.sv
// Text console with an 80x25 screen of 16-bit cells (attribute high byte, character
// low byte) held in one single-port-write, registered-read RAM. A put or a read is
// accepted in S_IDLE; in S_RESP the result is loaded into the output register once
// the output register is free, and only then is a new transaction taken. A put that
// moves past the last row scrolls the screen (S_COPY copies one cell per cycle through
// the RAM's single write port, then S_FILL writes one blank cell per cycle for the new
// bottom row). After reset the block clears all 2000 cells, during which in_ready
// stays low; color writes on the configuration port are taken at any time.
`include "assert_macros.svh"

module text_console_writer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tcw_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  import tcw_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RESP  = 5'b00100,
    S_COPY  = 5'b01000,
    S_FILL  = 5'b10000
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_BACK     = ADDR_W'(COLUMNS + 1);

  state_t            state_r, state_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic              copy_vld_r, copy_vld_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] offset_r, offset_nxt;
  logic [ATTR_W-1:0] color_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              resp_read_r, resp_read_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic in_fire;
  logic last_row;
  logic last_col;
  logic out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign last_row  = (row_r == ROW_W'(ROWS - 1));
  assign last_col  = (col_r == COL_W'(COLUMNS - 1));
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    copy_vld_nxt  = copy_vld_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    offset_nxt    = offset_r;
    resp_read_nxt = resp_read_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = offset_r;
    ram_wdata     = {color_r, in_data.char_code};
    ram_re        = 1'b0;
    ram_raddr     = in_data.read_index;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r[ADDR_W-1:0];
        ram_wdata = RESET_CELL;
        ptr_nxt   = ptr_r + PTR_W'(1);
        if (ptr_r == PTR_W'(CELL_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt     = S_RESP;
          resp_read_nxt = 1'b0;
          if (in_data.operation == OP_READ) begin
            if (32'(in_data.read_index) < CELL_COUNT) begin
              ram_re        = 1'b1;
              resp_read_nxt = 1'b1;
            end
          end else begin
            if (in_data.char_code != NEWLINE_CODE) begin
              ram_we = 1'b1;
            end
            if (in_data.char_code == NEWLINE_CODE || last_col) begin
              col_nxt = '0;
              if (last_row) begin
                offset_nxt   = LAST_ROW_BASE;
                state_nxt    = S_COPY;
                ptr_nxt      = PTR_W'(COLUMNS);
                copy_vld_nxt = 1'b0;
              end else begin
                row_nxt    = row_r + ROW_W'(1);
                offset_nxt = offset_r - ADDR_W'(col_r) + ADDR_W'(COLUMNS);
              end
            end else begin
              col_nxt    = col_r + COL_W'(1);
              offset_nxt = offset_r + ADDR_W'(1);
            end
          end
        end
      end
      S_COPY: begin
        ram_we    = copy_vld_r;
        ram_waddr = ptr_r[ADDR_W-1:0] - COPY_BACK;
        ram_wdata = ram_rdata;
        ram_raddr = ptr_r[ADDR_W-1:0];
        if (ptr_r != PTR_W'(CELL_COUNT)) begin
          ram_re       = 1'b1;
          ptr_nxt      = ptr_r + PTR_W'(1);
          copy_vld_nxt = 1'b1;
        end else begin
          copy_vld_nxt = 1'b0;
          ptr_nxt      = PTR_W'(LAST_ROW_BASE);
          state_nxt    = S_FILL;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r[ADDR_W-1:0];
        ram_wdata = {color_r, SPACE_CODE};
        ptr_nxt   = ptr_r + PTR_W'(1);
        if (ptr_r == PTR_W'(CELL_COUNT - 1)) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.cell_value    = resp_read_r ? ram_rdata : '0;
          out_data_nxt.cursor_row    = row_r;
          out_data_nxt.cursor_col    = col_r;
          out_data_nxt.cursor_offset = offset_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      copy_vld_r  <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      offset_r    <= '0;
      color_r     <= RESET_COLOR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      copy_vld_r  <= copy_vld_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    resp_read_r <= resp_read_nxt;
  end

  `TCW_ASSERT(a_cursor_range, clk, rst_n, 32'(row_r) < ROWS && 32'(col_r) < COLUMNS)
  `TCW_ASSERT(a_offset_match, clk, rst_n, 32'(offset_r) == 32'(row_r) * COLUMNS + 32'(col_r))
  `TCW_ASSERT_NEXT(a_accept_next, clk, rst_n, in_fire, state_r == S_RESP || state_r == S_COPY)

endmodule

// File: dv/tb_text_console_writer.sv
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int IDLE_LIMIT   = 12000;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 106;
  localparam int NL_PCT [PHASES] = '{15, 2, 10, 1, 6};
  localparam int DIR_ROWS     = 20;

  typedef struct packed {
    logic              op;
    logic [CHAR_W-1:0] code;
    logic [ADDR_W-1:0] idx;
    logic [7:0]        reps;
    logic              has_want;
    out_item_t         want;
  } stim_row_t;

  typedef struct packed {
    logic      has_want;
    out_item_t want;
  } fixed_result_t;

  // Rows with a typed result are checked against it; the others use the screen model.
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_READ, 8'h00, 11'd0,    8'd1,  1'b1, '{16'h0F20, 5'd0, 7'd0, 11'd0}},
    '{OP_READ, 8'hFF, 11'd1999, 8'd1,  1'b1, '{16'h0F20, 5'd0, 7'd0, 11'd0}},
    '{OP_READ, 8'h00, 11'd2000, 8'd1,  1'b1, '{16'h0000, 5'd0, 7'd0, 11'd0}},
    '{OP_READ, 8'h00, 11'd2047, 8'd1,  1'b1, '{16'h0000, 5'd0, 7'd0, 11'd0}},
    '{OP_PUT,  8'h41, 11'd0,    8'd1,  1'b1, '{16'h0000, 5'd0, 7'd1, 11'd1}},
    '{OP_READ, 8'h00, 11'd0,    8'd1,  1'b1, '{16'h0F41, 5'd0, 7'd1, 11'd1}},
    '{OP_PUT,  8'h00, 11'd2047, 8'd1,  1'b1, '{16'h0000, 5'd0, 7'd2, 11'd2}},
    '{OP_PUT,  8'hFF, 11'd0,    8'd1,  1'b1, '{16'h0000, 5'd0, 7'd3, 11'd3}},
    '{OP_READ, 8'h00, 11'd1,    8'd1,  1'b1, '{16'h0F00, 5'd0, 7'd3, 11'd3}},
    '{OP_READ, 8'h00, 11'd2,    8'd1,  1'b1, '{16'h0FFF, 5'd0, 7'd3, 11'd3}},
    '{OP_PUT,  8'h0A, 11'd0,    8'd1,  1'b1, '{16'h0000, 5'd1, 7'd0, 11'd80}},
    '{OP_PUT,  8'h0A, 11'd0,    8'd23, 1'b0, '0},
    '{OP_PUT,  8'h5A, 11'd0,    8'd79, 1'b0, '0},
    '{OP_PUT,  8'h61, 11'd0,    8'd1,  1'b0, '0},
    '{OP_READ, 8'h00, 11'd1840, 8'd1,  1'b0, '0},
    '{OP_READ, 8'h00, 11'd1920, 8'd1,  1'b0, '0},
    '{OP_PUT,  8'h0A, 11'd1024, 8'd1,  1'b0, '0},
    '{OP_READ, 8'h00, 11'd1760, 8'd1,  1'b0, '0},
    '{OP_READ, 8'h7F, 11'd1999, 8'd1,  1'b0, '0},
    '{OP_PUT,  8'h09, 11'd0,    8'd1,  1'b0, '0}
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;
  logic               cfg_wr_en;
  logic [7:0]         cfg_wr_data;

  logic [CELL_W-1:0]  screen_model [CELL_COUNT];
  int                 cur_row;
  int                 cur_col;
  logic [ATTR_W-1:0]  color_model;

  out_item_t          pending_results [$];
  fixed_result_t      fixed_results [$];

  int                 errors;
  int                 idle_cycles;
  int                 items_in;
  int                 results_seen;
  int                 scroll_count;
  int                 color_writes;
  int                 sent_count;
  bit                 src_burst;

  text_console_writer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void scroll_screen();
    for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
      screen_model[i] = screen_model[i + COLUMNS];
    end
    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
      screen_model[i] = {color_model, SPACE_CODE};
    end
    scroll_count++;
  endfunction

  function automatic void next_line();
    cur_col = 0;
    if (cur_row >= ROWS - 1) begin
      cur_row = ROWS - 1;
      scroll_screen();
    end else begin
      cur_row++;
    end
  endfunction

  function automatic out_item_t console_step(input in_item_t it);
    out_item_t res;
    res = '0;
    if (it.operation == OP_READ) begin
      if (it.read_index < CELL_COUNT) begin
        res.cell_value = screen_model[it.read_index];
      end
    end else if (it.char_code == NEWLINE_CODE) begin
      next_line();
    end else begin
      screen_model[cur_row * COLUMNS + cur_col] = {color_model, it.char_code};
      cur_col++;
      if (cur_col >= COLUMNS) begin
        next_line();
      end
    end
    res.cursor_row    = ROW_W'(cur_row);
    res.cursor_col    = COL_W'(cur_col);
    res.cursor_offset = ADDR_W'(cur_row * COLUMNS + cur_col);
    return res;
  endfunction

  function automatic in_item_t random_item(input int nl_pct);
    in_item_t it;
    int       pick;
    int       near;
    it.operation  = ($urandom_range(0, 99) < 35) ? OP_READ : OP_PUT;
    it.char_code  = CHAR_W'($urandom_range(0, 255));
    it.read_index = ADDR_W'($urandom_range(0, 2047));
    pick = $urandom_range(0, 99);
    if (it.operation == OP_PUT) begin
      if (pick < nl_pct) begin
        it.char_code = NEWLINE_CODE;
      end else if (pick < 75) begin
        it.char_code = CHAR_W'($urandom_range(32, 126));
      end
    end else if (pick < 50) begin
      near = cur_row * COLUMNS + cur_col - int'($urandom_range(0, 200));
      it.read_index = ADDR_W'((near < 0) ? 0 : near);
    end else if (pick < 88) begin
      it.read_index = ADDR_W'($urandom_range(0, CELL_COUNT - 1));
    end else begin
      it.read_index = ADDR_W'($urandom_range(CELL_COUNT, 2047));
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input logic has_want, input out_item_t want);
    int            gap;
    fixed_result_t fr;
    if (sent_count % 40 == 0) begin
      src_burst = ($urandom_range(0, 2) == 0);
    end
    gap = src_burst ? 0 : $urandom_range(0, 14);
    fr.has_want = has_want;
    fr.want     = want;
    fixed_results.push_back(fr);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_color(input logic [7:0] color);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= color;
    @(posedge clk);
    color_model = color;
    color_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    fixed_result_t fr;
    out_item_t     want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (in_valid && in_ready) begin
        want = console_step(in_data);
        fr = fixed_results.pop_front();
        if (fr.has_want) begin
          want = fr.want;
        end
        pending_results.push_back(want);
        items_in++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result with no transaction waiting: cell %h row %0d col %0d",
                     $time, out_data.cell_value, out_data.cursor_row, out_data.cursor_col);
          end
        end else begin
          want = pending_results.pop_front();
          if (out_data.cell_value !== want.cell_value ||
              out_data.cursor_row !== want.cursor_row ||
              out_data.cursor_col !== want.cursor_col ||
              out_data.cursor_offset !== want.cursor_offset) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch, expected cell %h row %0d col %0d offset %0d",
                       $time, want.cell_value, want.cursor_row, want.cursor_col,
                       want.cursor_offset);
              $display("%0t:           got      cell %h row %0d col %0d offset %0d",
                       $time, out_data.cell_value, out_data.cursor_row,
                       out_data.cursor_col, out_data.cursor_offset);
            end
          end
        end
      end
    end
  end

  initial begin
    int  gap;
    bit  burst;
    bit  held;
    out_ready = 1'b0;
    burst     = 1'b0;
    held      = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (results_seen % 40 == 0) begin
        burst = ($urandom_range(0, 2) == 0);
      end
      gap = burst ? 0 : $urandom_range(0, 14);
      if (!held && results_seen >= 300) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    idle_cycles = 0;
    wait (rst_n === 1'b1);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Watchdog: no transaction for %0d cycles.", IDLE_LIMIT);
    $display("tb_text_console_writer: errors");
    $finish;
  end

  initial begin
    in_item_t    it;
    logic [7:0]  color;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    rst_n        = 1'b0;
    errors       = 0;
    items_in     = 0;
    results_seen = 0;
    scroll_count = 0;
    color_writes = 0;
    sent_count   = 0;
    src_burst    = 1'b0;
    cur_row      = 0;
    cur_col      = 0;
    color_model  = RESET_COLOR;
    for (int i = 0; i < CELL_COUNT; i++) begin
      screen_model[i] = RESET_CELL;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      for (int k = 0; k < DIRECTED[r].reps; k++) begin
        it.operation  = DIRECTED[r].op;
        it.char_code  = DIRECTED[r].code;
        it.read_index = DIRECTED[r].idx;
        send_item(it, DIRECTED[r].has_want, DIRECTED[r].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: color = 8'h00;
        1: color = 8'hFF;
        3: color = 8'h4E;
        default: color = 8'($urandom_range(0, 255));
      endcase
      set_color(color);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_item(NL_PCT[p]), 1'b0, '0);
      end
    end
    drain();

    $display("Checked %0d results from %0d transactions over %0d text colors.",
             results_seen, items_in, color_writes + 1);
    $display("The screen scrolled %0d times; %0d mismatches were found.",
             scroll_count, errors);
    if (errors == 0) begin
      $display("tb_text_console_writer: clean");
    end else begin
      $display("tb_text_console_writer: errors");
    end
    $finish;
  end

endmodule
